[hw/rtl/lzvg_pkg.sv]
// Package for the lidar zone velocity gate.
// Holds the shared constants, register indexes, decision codes and structs.
// No dependencies.
package lzvg_pkg;

  localparam int unsigned Regions     = 4;
  localparam int unsigned CountW      = 13;
  localparam int unsigned RangeW      = 16;
  localparam int unsigned BoundW      = 16;
  localparam int unsigned SpeedW      = 16;
  localparam int unsigned LimitW      = 13;
  localparam int unsigned TurnSpeedW  = 15;
  localparam int unsigned MaxBeamsDef = 4096;
  localparam int unsigned MinTurnRate = 20;
  localparam int unsigned AddrW       = 6;
  localparam int unsigned DataW       = 64;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Region order inside the packed bounds and counts.
  localparam int unsigned RegRightOuter = 0;
  localparam int unsigned RegRightInner = 1;
  localparam int unsigned RegLeftInner  = 2;
  localparam int unsigned RegLeftOuter  = 3;

  typedef enum logic [2:0] {
    REG_REGION_STARTS = 3'd0,
    REG_REGION_ENDS   = 3'd1,
    REG_MIN_RANGE     = 3'd2,
    REG_NEAR_RANGE    = 3'd3,
    REG_FAR_RANGE     = 3'd4,
    REG_NEAR_LIMIT    = 3'd5,
    REG_FAR_LIMIT     = 3'd6,
    REG_TURN_SPEED    = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    DEC_UNCHANGED   = 3'd0,
    DEC_STOP        = 3'd1,
    DEC_LEFT_NEAR   = 3'd2,
    DEC_RIGHT_NEAR  = 3'd3,
    DEC_LEFT_FAR    = 3'd4,
    DEC_RIGHT_FAR   = 3'd5,
    DEC_TURN_CANCEL = 3'd6
  } dec_e;

  // Item kinds carried in tuser.
  localparam logic CmdBeam     = 1'b0;
  localparam logic CmdVelocity = 1'b1;

  typedef struct packed {
    logic [Regions-1:0][BoundW-1:0] starts;
    logic [Regions-1:0][BoundW-1:0] ends;
    logic [RangeW-1:0]              min_range;
    logic [RangeW-1:0]              near_range;
    logic [RangeW-1:0]              far_range;
  } scan_cfg_t;

  typedef struct packed {
    logic [Regions-1:0][CountW-1:0] near;
    logic [Regions-1:0][CountW-1:0] far;
    logic                           scan_done;
  } scan_counts_t;

endpackage

[hw/rtl/lzvg_scan_counter.sv]
// Per-region beam counter of the lidar zone velocity gate.
// Counts near and far beams of the scan in progress and publishes them on the last beam.
// Depends on lzvg_pkg.
module lzvg_scan_counter #(
  parameter int unsigned MAX_BEAMS = lzvg_pkg::MaxBeamsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             beam_en_i,
  input  logic [lzvg_pkg::RangeW-1:0]      beam_range_i,
  input  logic                             last_beam_i,
  input  lzvg_pkg::scan_cfg_t              cfg_i,
  output lzvg_pkg::scan_counts_t           counts_o
);

  localparam int unsigned IdxW = $clog2(MAX_BEAMS + 1);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_BEAMS);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [lzvg_pkg::Regions-1:0][lzvg_pkg::CountW-1:0] near_acc_q, near_acc_d;
  logic [lzvg_pkg::Regions-1:0][lzvg_pkg::CountW-1:0] far_acc_q, far_acc_d;
  lzvg_pkg::scan_counts_t pub_q, pub_d;

  logic                        idx_ok;
  logic                        range_ok;
  logic                        is_near;
  logic [lzvg_pkg::BoundW-1:0] idx_ext;

  assign idx_ext  = lzvg_pkg::BoundW'(idx_q);
  assign idx_ok   = idx_q < IdxMax;
  assign range_ok = (beam_range_i >= cfg_i.min_range) && (beam_range_i <= cfg_i.far_range);
  assign is_near  = beam_range_i < cfg_i.near_range;

  always_comb begin
    near_acc_d = near_acc_q;
    far_acc_d  = far_acc_q;
    idx_d      = idx_q;
    pub_d      = pub_q;
    if (beam_en_i) begin
      // Four regions compare in parallel; counts saturate.
      for (int r = 0; r < lzvg_pkg::Regions; r++) begin
        if (idx_ok && range_ok && (idx_ext >= cfg_i.starts[r]) &&
            (idx_ext <= cfg_i.ends[r])) begin
          if (far_acc_q[r] != lzvg_pkg::CountMax) begin
            far_acc_d[r] = far_acc_q[r] + lzvg_pkg::CountW'(1);
          end
          if (is_near && (near_acc_q[r] != lzvg_pkg::CountMax)) begin
            near_acc_d[r] = near_acc_q[r] + lzvg_pkg::CountW'(1);
          end
        end
      end
      if (idx_ok) begin
        idx_d = idx_q + IdxW'(1);
      end
      if (last_beam_i) begin
        // Publish the scan including this beam, then start over.
        pub_d.near      = near_acc_d;
        pub_d.far       = far_acc_d;
        pub_d.scan_done = 1'b1;
        near_acc_d      = '0;
        far_acc_d       = '0;
        idx_d           = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      near_acc_q <= '0;
      far_acc_q  <= '0;
      pub_q      <= '0;
    end else begin
      idx_q      <= idx_d;
      near_acc_q <= near_acc_d;
      far_acc_q  <= far_acc_d;
      pub_q      <= pub_d;
    end
  end

  assign counts_o = pub_q;

endmodule

[hw/rtl/lidar_zone_velocity_gate.sv]
// Lidar zone velocity gate, top level; depends on lzvg_pkg and lzvg_scan_counter.
// A velocity item passes through the input register and then the result register;
// beams, and velocity items before the first published scan, give no result.
// Throughput: one item per cycle; stall only while a waiting result blocks a velocity item.
// Reset (rst_ni, asynchronous): clears counts, scan state and handshakes; registers
// take their documented defaults. No clearing pass.
module lidar_zone_velocity_gate #(
  parameter int unsigned MAX_BEAMS = lzvg_pkg::MaxBeamsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Item input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] beam_range, [31:16] linear_speed, [47:32] turn_rate
  input  logic [47:0]                  s_axis_tdata,
  // [0] command (0 beam, 1 velocity)
  input  logic                         s_axis_tuser,
  input  logic                         s_axis_tlast,
  // Result output
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [15:0] out_linear, [31:16] out_turn, [34:32] decision, [39:35] zero
  output logic [39:0]                  m_axis_tdata,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lzvg_pkg::AddrW-1:0]   paddr,
  input  logic [lzvg_pkg::DataW-1:0]   pwdata,
  output logic [lzvg_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned SW = lzvg_pkg::SpeedW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  lzvg_pkg::scan_cfg_t               scan_cfg_q;
  logic [lzvg_pkg::LimitW-1:0]       near_limit_q;
  logic [lzvg_pkg::LimitW-1:0]       far_limit_q;
  logic [lzvg_pkg::TurnSpeedW-1:0]   turn_speed_q;
  logic                              cfg_wr;
  lzvg_pkg::reg_e                    cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = lzvg_pkg::reg_e'(paddr[lzvg_pkg::AddrW-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cfg_q.starts     <= '0;
      scan_cfg_q.ends       <= '0;
      scan_cfg_q.min_range  <= '0;
      scan_cfg_q.near_range <= lzvg_pkg::RangeW'(300);
      scan_cfg_q.far_range  <= lzvg_pkg::RangeW'(800);
      near_limit_q          <= lzvg_pkg::LimitW'(10);
      far_limit_q           <= lzvg_pkg::LimitW'(15);
      turn_speed_q          <= lzvg_pkg::TurnSpeedW'(600);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        lzvg_pkg::REG_REGION_STARTS: scan_cfg_q.starts     <= pwdata;
        lzvg_pkg::REG_REGION_ENDS:   scan_cfg_q.ends       <= pwdata;
        lzvg_pkg::REG_MIN_RANGE:     scan_cfg_q.min_range  <= pwdata[15:0];
        lzvg_pkg::REG_NEAR_RANGE:    scan_cfg_q.near_range <= pwdata[15:0];
        lzvg_pkg::REG_FAR_RANGE:     scan_cfg_q.far_range  <= pwdata[15:0];
        lzvg_pkg::REG_NEAR_LIMIT:    near_limit_q          <= pwdata[12:0];
        lzvg_pkg::REG_FAR_LIMIT:     far_limit_q           <= pwdata[12:0];
        lzvg_pkg::REG_TURN_SPEED:    turn_speed_q          <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register, zero-extended.
  always_comb begin
    unique case (cfg_sel)
      lzvg_pkg::REG_REGION_STARTS: prdata = scan_cfg_q.starts;
      lzvg_pkg::REG_REGION_ENDS:   prdata = scan_cfg_q.ends;
      lzvg_pkg::REG_MIN_RANGE:     prdata = lzvg_pkg::DataW'(scan_cfg_q.min_range);
      lzvg_pkg::REG_NEAR_RANGE:    prdata = lzvg_pkg::DataW'(scan_cfg_q.near_range);
      lzvg_pkg::REG_FAR_RANGE:     prdata = lzvg_pkg::DataW'(scan_cfg_q.far_range);
      lzvg_pkg::REG_NEAR_LIMIT:    prdata = lzvg_pkg::DataW'(near_limit_q);
      lzvg_pkg::REG_FAR_LIMIT:     prdata = lzvg_pkg::DataW'(far_limit_q);
      lzvg_pkg::REG_TURN_SPEED:    prdata = lzvg_pkg::DataW'(turn_speed_q);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                         in_valid_q;
  logic                         cmd_q;
  logic                         last_q;
  logic [lzvg_pkg::RangeW-1:0]  range_q;
  logic signed [SW-1:0]         lin_q;
  logic signed [SW-1:0]         turn_q;

  logic                         in_fire;
  logic                         makes_result;
  logic                         stage_move;
  logic                         out_valid_q;
  lzvg_pkg::scan_counts_t       counts;

  // Only a velocity item after the first scan needs a free result slot.
  assign makes_result  = (cmd_q == lzvg_pkg::CmdVelocity) && counts.scan_done;
  assign stage_move    = in_valid_q && (!makes_result || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || stage_move;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= s_axis_tuser;
      last_q  <= s_axis_tlast;
      range_q <= s_axis_tdata[15:0];
      lin_q   <= s_axis_tdata[31:16];
      turn_q  <= s_axis_tdata[47:32];
    end
  end

  // ---------------------------------------------------------------------------
  // Beam counting
  // ---------------------------------------------------------------------------
  logic beam_en;

  assign beam_en = stage_move && (cmd_q == lzvg_pkg::CmdBeam);

  lzvg_scan_counter #(
    .MAX_BEAMS (MAX_BEAMS)
  ) u_scan_counter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beam_en_i    (beam_en),
    .beam_range_i (range_q),
    .last_beam_i  (last_q),
    .cfg_i        (scan_cfg_q),
    .counts_o     (counts)
  );

  // ---------------------------------------------------------------------------
  // Velocity gating against the published counts
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] olin_d;
  logic signed [SW-1:0] oturn_d;
  lzvg_pkg::dec_e       dec_d;
  logic signed [SW-1:0] ts_pos;
  logic                 rn, ln, rf, lf, lo_near, ro_near, fast_turn;

  assign ts_pos  = SW'(turn_speed_q);
  assign rn      = counts.near[lzvg_pkg::RegRightInner] > near_limit_q;
  assign ln      = counts.near[lzvg_pkg::RegLeftInner]  > near_limit_q;
  assign rf      = counts.far[lzvg_pkg::RegRightInner]  > far_limit_q;
  assign lf      = counts.far[lzvg_pkg::RegLeftInner]   > far_limit_q;
  assign ro_near = counts.near[lzvg_pkg::RegRightOuter] > near_limit_q;
  assign lo_near = counts.near[lzvg_pkg::RegLeftOuter]  > near_limit_q;
  // |turn| > MinTurnRate without forming the magnitude.
  assign fast_turn = (turn_q > $signed(SW'(lzvg_pkg::MinTurnRate))) ||
                     (turn_q < -$signed(SW'(lzvg_pkg::MinTurnRate)));

  always_comb begin
    olin_d  = lin_q;
    oturn_d = turn_q;
    dec_d   = lzvg_pkg::DEC_UNCHANGED;
    if (lin_q > $signed(SW'(0))) begin
      // Forward: stop when both inner sides are near, else steer away.
      if (rn && ln) begin
        olin_d  = '0;
        oturn_d = '0;
        dec_d   = lzvg_pkg::DEC_STOP;
      end else if (rn) begin
        oturn_d = ts_pos;
        dec_d   = lzvg_pkg::DEC_LEFT_NEAR;
      end else if (ln) begin
        oturn_d = -ts_pos;
        dec_d   = lzvg_pkg::DEC_RIGHT_NEAR;
      end else if (rf) begin
        oturn_d = ts_pos;
        dec_d   = lzvg_pkg::DEC_LEFT_FAR;
      end else if (lf) begin
        oturn_d = -ts_pos;
        dec_d   = lzvg_pkg::DEC_RIGHT_FAR;
      end
    end else if (fast_turn) begin
      // Cancel a turn into a blocked outer region.
      if ((turn_q > $signed(SW'(0)) && lo_near) || (turn_q < $signed(SW'(0)) && ro_near)) begin
        oturn_d = '0;
        dec_d   = lzvg_pkg::DEC_TURN_CANCEL;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                 out_load;
  logic signed [SW-1:0] olin_q;
  logic signed [SW-1:0] oturn_q;
  lzvg_pkg::dec_e       dec_q;

  assign out_load = stage_move && makes_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      olin_q  <= olin_d;
      oturn_q <= oturn_d;
      dec_q   <= dec_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, dec_q, oturn_q, olin_q};

endmodule
